// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker in sid_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle, consequent must hold in the same cycle
`define SID_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// antecedent holds in this cycle, consequent must hold in the next cycle
`define SID_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- rtl/sid_pkg.sv -----
package sid_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int STEP_CNT_WIDTH = 5;
   localparam logic [STEP_CNT_WIDTH-1:0] LAST_STEP = 5'd31;

   localparam logic [DATA_WIDTH-1:0] INT_MIN_PATTERN   = 32'h8000_0000;
   localparam logic [DATA_WIDTH-1:0] INT_MAX_PATTERN   = 32'h7FFF_FFFF;
   localparam logic [DATA_WIDTH-1:0] MINUS_ONE_PATTERN = 32'hFFFF_FFFF;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture operands and take magnitudes
      logic step;    // one shift and subtract
      logic finish;  // sign or saturate the quotient into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic special; // zero divisor or overflow, no iterations needed
   } status_type;

endpackage

// ----- rtl/sid_channel_if.sv -----
interface sid_req_if;
   import sid_pkg::*;
   logic     valid;
   logic     ready;
   data_type dividend;
   data_type divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface sid_rsp_if;
   import sid_pkg::*;
   logic     valid;
   logic     ready;
   data_type quotient;

   modport source (output valid, output quotient, input ready);
   modport sink (input valid, input quotient, output ready);
endinterface

// ----- rtl/signed_int32_divider.sv -----
// channel | dir | handshake           | payload
// req_if  | in  | valid / ready       | dividend (s32), divisor (s32)
// rsp_if  | out | valid / ready       | quotient (s32)
//
// one item at a time; ready is high only while the controller is idle
// operands load on the accepting edge; a normal result takes
// 32 shift and subtract steps through the single 34-bit subtractor, then a sign step
// zero divisor and overflow skip the steps: the divide state passes straight to the sign step
// the next item is accepted once the controller is back in idle after the sign step;
// the result register holds an item until taken, and a new item accepted
// meanwhile waits in its sign cycle until the result register frees up
// synchronous active-high reset clears the controller; payload registers keep
module signed_int32_divider (
   input logic        clock,
   input logic        reset,
   sid_req_if.sink    req_if,
   sid_rsp_if.source  rsp_if
);
   import sid_pkg::*;

   // command and status between controller and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: idle, divide steps, finish into the result register
   sid_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // magnitudes, restoring divide, sign and result register
   sid_datapath u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .dividend (req_if.dividend),
      .divisor  (req_if.divisor),
      .status   (status),
      .quotient (rsp_if.quotient)
   );

endmodule

// ----- rtl/sid_datapath.sv -----
module sid_datapath (
   input  logic                 clock,
   input  sid_pkg::cmd_type     cmd,
   input  sid_pkg::data_type    dividend,
   input  sid_pkg::data_type    divisor,
   output sid_pkg::status_type  status,
   output sid_pkg::data_type    quotient
);
   import sid_pkg::*;

   logic [DATA_WIDTH-1:0] a_bits;
   logic [DATA_WIDTH-1:0] b_bits;
   logic [DATA_WIDTH-1:0] mag_a;
   logic [DATA_WIDTH-1:0] mag_b;
   logic                  special_det;

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic                  special_ff, special_in;
   logic [DATA_WIDTH-1:0] result_ff, result_in;

   logic [DATA_WIDTH:0]   rem_shift;
   logic [DATA_WIDTH+1:0] diff;
   logic                  fits;

   assign a_bits = dividend;
   assign b_bits = divisor;
   assign mag_a  = a_bits[DATA_WIDTH-1] ? (~a_bits + 1'b1) : a_bits;
   assign mag_b  = b_bits[DATA_WIDTH-1] ? (~b_bits + 1'b1) : b_bits;
   assign special_det = (b_bits == '0) ||
                        (a_bits == INT_MIN_PATTERN && b_bits == MINUS_ONE_PATTERN);

   // restoring step: dividend bits leave quo_ff at the top, quotient bits enter below
   assign rem_shift = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, den_ff};
   assign fits      = ~diff[DATA_WIDTH+1];

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      den_in     = den_ff;
      neg_in     = neg_ff;
      special_in = special_ff;
      result_in  = result_ff;
      if (cmd.load) begin
         rem_in     = '0;
         quo_in     = mag_a;
         den_in     = mag_b;
         neg_in     = a_bits[DATA_WIDTH-1] ^ b_bits[DATA_WIDTH-1];
         special_in = special_det;
      end
      if (cmd.step) begin
         rem_in = fits ? diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
      end
      if (cmd.finish) begin
         if (special_ff) begin
            result_in = INT_MAX_PATTERN;
         end else if (neg_ff) begin
            result_in = ~quo_ff + 1'b1;
         end else begin
            result_in = quo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      special_ff <= special_in;
      result_ff  <= result_in;
   end

   assign status.special = special_ff;
   assign quotient       = result_ff;

endmodule

// ----- rtl/sid_controller.sv -----
module sid_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  sid_pkg::status_type status,
   output sid_pkg::cmd_type    cmd
);
   import sid_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [STEP_CNT_WIDTH-1:0] count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_free;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) & ~reset;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.special) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
               count_in = count_ff + 1'b1;
               if (count_ff == LAST_STEP) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/sid_checker.sv -----
`include "assert_macros.svh"

module sid_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sid_pkg::data_type rsp_quotient
);
   import sid_pkg::*;

   logic       req_fire;
   logic       rsp_fire;
   logic [1:0] cnt_ff, cnt_in;

   assign req_fire = req_valid & req_ready;
   assign rsp_fire = rsp_valid & rsp_ready;

   // items accepted but not yet delivered
   always_comb begin
      cnt_in = cnt_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `SID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_quotient))
   `SID_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire, !req_ready)
   `SID_ASSERT_NOW(a_no_invented, clock, reset, rsp_valid, cnt_ff != 2'd0)
   `SID_ASSERT_NOW(a_two_outstanding, clock, reset, cnt_ff == 2'd2, !req_ready)

endmodule

bind signed_int32_divider sid_checker u_sid_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_quotient (rsp_if.quotient)
);

// ----- verif/signed_int32_divider_checker.sv -----
`timescale 1ns / 100ps

module signed_int32_divider_checker (
   input  logic clock,
   input  logic reset,
   sid_req_if   req_mon,
   sid_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_count
);
   import sid_pkg::*;

   data_type quotients_due[$];

   // truncating signed division, saturating on zero divisor and on overflow
   function automatic data_type expected_quotient(input data_type dividend,
                                                  input data_type divisor);
      logic [DATA_WIDTH-1:0] mag_dividend;
      logic [DATA_WIDTH-1:0] mag_divisor;
      logic [DATA_WIDTH-1:0] mag_quotient;
      logic                  negative;
      if (divisor == '0 ||
          (dividend == INT_MIN_PATTERN && divisor == MINUS_ONE_PATTERN)) begin
         return INT_MAX_PATTERN;
      end
      mag_dividend = dividend[DATA_WIDTH-1] ? DATA_WIDTH'(-dividend) : dividend;
      mag_divisor  = divisor[DATA_WIDTH-1] ? DATA_WIDTH'(-divisor) : divisor;
      mag_quotient = mag_dividend / mag_divisor;
      negative     = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      return negative ? DATA_WIDTH'(-mag_quotient) : mag_quotient;
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      data_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            quotients_due.push_back(expected_quotient(req_mon.dividend, req_mon.divisor));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (quotients_due.size() == 0) begin
               if (error_count < 10) begin
                  $display("%0t: quotient %0d arrived with no item outstanding",
                           $realtime, rsp_mon.quotient);
               end
               error_count = error_count + 1;
            end else begin
               want = quotients_due.pop_front();
               if (rsp_mon.quotient !== want) begin
                  if (error_count < 10) begin
                     $display("%0t: quotient mismatch, expected %0d (%h) got %0d (%h)",
                              $realtime, want, want, rsp_mon.quotient, rsp_mon.quotient);
                  end
                  error_count = error_count + 1;
               end
            end
         end
         pending_count = quotients_due.size();
      end
   end

endmodule

// ----- verif/signed_int32_divider_tb.sv -----
`timescale 1ns / 100ps

module signed_int32_divider_tb;
   import sid_pkg::*;

   // generous bound: ~1000 items plus gaps and stalls, taken several times
   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_ITEMS   = 240;
   localparam int DIRECTED_ITEMS = 24;

   // directed pairs: saturation cases, wrap of the most negative value over one,
   // sign combinations, extremes of both fields
   localparam data_type DIRECTED_DIVIDEND [DIRECTED_ITEMS] = '{
      32'sd0, 32'sd1, INT_MAX_PATTERN, INT_MIN_PATTERN, INT_MIN_PATTERN,
      INT_MIN_PATTERN, INT_MAX_PATTERN, 32'sd0, -32'sd1, INT_MAX_PATTERN,
      INT_MIN_PATTERN, INT_MAX_PATTERN, INT_MIN_PATTERN, INT_MAX_PATTERN,
      -32'sd7, 32'sd7, -32'sd7, 32'sd7, 32'sd5, -32'sd1,
      INT_MIN_PATTERN, INT_MIN_PATTERN, 32'sd1, -32'sd1
   };
   localparam data_type DIRECTED_DIVISOR [DIRECTED_ITEMS] = '{
      32'sd1, 32'sd1, 32'sd1, 32'sd1, MINUS_ONE_PATTERN,
      32'sd0, 32'sd0, 32'sd0, 32'sd0, MINUS_ONE_PATTERN,
      INT_MIN_PATTERN, INT_MIN_PATTERN, INT_MAX_PATTERN, INT_MAX_PATTERN,
      32'sd2, -32'sd2, -32'sd2, 32'sd2, 32'sd10, -32'sd1,
      32'sd2, -32'sd2, INT_MIN_PATTERN, INT_MAX_PATTERN
   };

   localparam data_type CORNER_VALUES [8] = '{
      INT_MIN_PATTERN, INT_MAX_PATTERN, 32'sd0, -32'sd1, 32'sd1, 32'sd2, -32'sd2,
      32'sh4000_0000
   };

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   sender_idle_pct;
   int   receiver_stall_pct;

   sid_req_if req_chan ();
   sid_rsp_if rsp_chan ();

   signed_int32_divider dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   signed_int32_divider_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run as a failure
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("signed_int32_divider_tb: done, errors");
      $finish;
   end

   // result side: stalls come in short bursts so they land on every phase,
   // including while a finished item waits and the next one is being divided
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(99) < receiver_stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // present one item at a falling edge and hold it until the block takes it
   task automatic send_division(input data_type dividend, input data_type divisor);
      int gap;
      if ($urandom_range(99) < sender_idle_pct) begin
         // mostly short gaps, now and then one long enough to outlast a division
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 3);
         req_chan.valid <= 1'b0;
         repeat (gap) begin
            // junk on the payload while valid is low
            req_chan.dividend <= $urandom;
            req_chan.divisor  <= $urandom;
            @(negedge clock);
         end
      end
      req_chan.valid    <= 1'b1;
      req_chan.dividend <= dividend;
      req_chan.divisor  <= divisor;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // sender holds off until every outstanding quotient has come back
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // operand pair drawn from a mix of shapes that reach the interesting corners
   task automatic pick_operands(output data_type dividend, output data_type divisor);
      data_type factor;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            // full range, covers every bit of both fields
            dividend = $urandom;
            divisor  = $urandom;
         end
         4: begin
            // tiny divisor, zero included
            dividend = $urandom;
            divisor  = data_type'($urandom_range(32)) - 32'sd16;
         end
         5: begin
            // divisor of random bit length and sign
            dividend = $urandom;
            divisor  = $urandom >> $urandom_range(31);
            if ($urandom_range(1)) divisor = -divisor;
         end
         6: begin
            // saturation and wrap corners against anything
            dividend = CORNER_VALUES[$urandom_range(7)];
            divisor  = $urandom_range(1) ? CORNER_VALUES[$urandom_range(7)] : $urandom;
         end
         7: begin
            // magnitude of divisor above dividend, quotient zero (but for divisors zero and minus one)
            divisor  = $urandom;
            dividend = divisor >>> $urandom_range(1, 31);
            if ($urandom_range(1)) dividend = -dividend;
         end
         8: begin
            // divisor right around the dividend
            dividend = $urandom;
            case ($urandom_range(3))
               0:       divisor = dividend;
               1:       divisor = -dividend;
               2:       divisor = dividend + 32'sd1;
               default: divisor = dividend - 32'sd1;
            endcase
         end
         default: begin
            // exact multiples, no remainder
            divisor  = data_type'($urandom_range(2000)) - 32'sd1000;
            factor   = data_type'($urandom_range(2000000)) - 32'sd1000000;
            dividend = divisor * factor;
         end
      endcase
   endtask

   // one random phase with the given idle and stall rates
   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      data_type dividend;
      data_type divisor;
      hold_until_drained();
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (PHASE_ITEMS) begin
         pick_operands(dividend, divisor);
         send_division(dividend, divisor);
      end
   endtask

   initial begin
      reset              = 1'b1;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      req_chan.valid     = 1'b0;
      req_chan.dividend  = '0;
      req_chan.divisor   = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items back to back, no idling on either side
      for (int i = 0; i < DIRECTED_ITEMS; i++) begin
         send_division(DIRECTED_DIVIDEND[i], DIRECTED_DIVISOR[i]);
      end

      // random phases: free running, idle sender, stalling receiver, both
      run_random_phase(0, 0);
      run_random_phase(56, 0);
      run_random_phase(0, 56);
      run_random_phase(20, 20);

      // wait for the last quotient, then leave room for anything stray
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("signed_int32_divider_tb: done, clean");
      end else begin
         $display("signed_int32_divider_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sid_pkg.sv
rtl/sid_channel_if.sv
rtl/sid_datapath.sv
rtl/sid_controller.sv
rtl/signed_int32_divider.sv
rtl/sid_checker.sv
verif/signed_int32_divider_checker.sv
verif/signed_int32_divider_tb.sv
